[hw/rtl/wcnm_pkg.sv]
// Shared types and constants for the wildcard contour NFA matcher.
// Holds the symbol classes, the front-to-back command and register indexes.
// No dependencies.
package wcnm_pkg;

  // Largest number of NFA states the datapath supports
  localparam int MAX_STATES     = 64;
  localparam int NUM_STATES_DEF = 64;

  // Field widths
  localparam int SYM_W    = 8;
  localparam int POS_W    = 32;
  localparam int LEN_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Text bytes that carry meaning
  localparam logic [SYM_W-1:0] SYM_UP    = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0] SYM_SHARP = 8'h23;  // '#'
  localparam logic [SYM_W-1:0] SYM_DOWN  = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] SYM_FLAT  = 8'h62;  // 'b'
  localparam logic [SYM_W-1:0] SYM_SAME  = 8'h3D;  // '='
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;  // '0'

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADV_UP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_SHARP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_FLAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADV_SAME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd6;

  // Symbol class decided by the front end
  typedef enum logic [2:0] {
    CLS_UP,
    CLS_SHARP,
    CLS_DOWN,
    CLS_FLAT,
    CLS_SAME,
    CLS_ZERO,
    CLS_OTHER
  } sym_class_t;

  // One classified text byte as it travels to the back end
  typedef struct packed {
    sym_class_t cls;
    logic       text_start;
    logic       text_end;
  } cmd_t;

  function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
    sym_class_t cls;
    case (sym)
      SYM_UP:    cls = CLS_UP;
      SYM_SHARP: cls = CLS_SHARP;
      SYM_DOWN:  cls = CLS_DOWN;
      SYM_FLAT:  cls = CLS_FLAT;
      SYM_SAME:  cls = CLS_SAME;
      SYM_ZERO:  cls = CLS_ZERO;
      default:   cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

[hw/rtl/wcnm_front.sv]
// Front end: takes text bytes from the input channel and classifies them.
// Registers one classified command toward the queue. Uses wcnm_pkg.
module wcnm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wcnm_pkg::SYM_W-1:0]     in_symbol,
  input  logic                           in_text_start,
  input  logic                           in_text_end,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output wcnm_pkg::cmd_t                 cmd
);

  logic           vld_r, vld_nxt;
  wcnm_pkg::cmd_t cmd_r, cmd_nxt;
  logic           take;

  // Stage may load when empty or when its content moves on
  assign in_ready = !vld_r || cmd_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    cmd_nxt = cmd_r;
    if (take) begin
      vld_nxt            = 1'b1;
      cmd_nxt.cls        = wcnm_pkg::classify(in_symbol);
      cmd_nxt.text_start = in_text_start;
      cmd_nxt.text_end   = in_text_end;
    end else if (cmd_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload carries no reset
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

endmodule

[hw/rtl/wcnm_queue.sv]
// Two-entry command queue between the front end and the back end.
// Lets either side stall without stopping the other. Uses wcnm_pkg.
module wcnm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wcnm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wcnm_pkg::cmd_t pop_cmd
);

  wcnm_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/wcnm_back.sv]
// Back end: holds the pattern registers and the NFA state, steps the
// active set once per command and drives the result register. Uses wcnm_pkg.
module wcnm_back #(
  parameter int NUM_STATES = wcnm_pkg::NUM_STATES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pattern register writes
  input  logic                              cfg_we,
  input  logic [wcnm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wcnm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // commands from the queue
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  wcnm_pkg::cmd_t                    cmd,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_match_now,
  output logic [wcnm_pkg::POS_W-1:0]        out_match_position,
  output logic                              out_text_done,
  output logic                              out_text_matched
);

  localparam int ADV_W = NUM_STATES - 1;

  // Pattern registers; an advance bit at the top state would shift out
  logic [ADV_W-1:0]              adv_up_r, adv_sharp_r, adv_down_r, adv_flat_r, adv_same_r;
  logic [NUM_STATES-1:0]         hold_r;
  logic [wcnm_pkg::LEN_W-1:0]    len_r;

  // Per-text state
  logic [NUM_STATES-1:0]         set_r, set_nxt;
  logic [wcnm_pkg::POS_W-1:0]    idx_r, idx_nxt;
  logic                          found_r, found_nxt;

  // Result register
  logic                          ovld_r, ovld_nxt;
  logic                          now_r, now_nxt;
  logic [wcnm_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                          done_r, done_nxt;
  logic                          matched_r, matched_nxt;

  logic                          step;
  logic [NUM_STATES-1:0]         base_set, stepped;
  logic [wcnm_pkg::POS_W-1:0]    base_idx;
  logic                          base_found;
  logic [ADV_W-1:0]              adv;
  logic [wcnm_pkg::MAX_STATES-1:0] set_wide;
  logic                          hit;

  // Pattern register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_up_r    <= '0;
      adv_sharp_r <= '0;
      adv_down_r  <= '0;
      adv_flat_r  <= '0;
      adv_same_r  <= '0;
      hold_r      <= NUM_STATES'(1);
      len_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wcnm_pkg::REG_ADV_UP:    adv_up_r    <= cfg_data[ADV_W-1:0];
        wcnm_pkg::REG_ADV_SHARP: adv_sharp_r <= cfg_data[ADV_W-1:0];
        wcnm_pkg::REG_ADV_DOWN:  adv_down_r  <= cfg_data[ADV_W-1:0];
        wcnm_pkg::REG_ADV_FLAT:  adv_flat_r  <= cfg_data[ADV_W-1:0];
        wcnm_pkg::REG_ADV_SAME:  adv_same_r  <= cfg_data[ADV_W-1:0];
        wcnm_pkg::REG_HOLD:      hold_r      <= cfg_data[NUM_STATES-1:0];
        wcnm_pkg::REG_PAT_LEN:   len_r       <= cfg_data[wcnm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Step whenever the result register is free or drains this cycle
  assign cmd_ready = !ovld_r || out_ready;
  assign step      = cmd_valid && cmd_ready;

  // Text start restarts from state zero before the byte
  assign base_set   = cmd.text_start ? NUM_STATES'(1) : set_r;
  assign base_idx   = cmd.text_start ? '0 : idx_r;
  assign base_found = cmd.text_start ? 1'b0 : found_r;

  // Advance mask by symbol class
  always_comb begin
    case (cmd.cls)
      wcnm_pkg::CLS_UP:    adv = adv_up_r;
      wcnm_pkg::CLS_SHARP: adv = adv_sharp_r;
      wcnm_pkg::CLS_DOWN:  adv = adv_down_r;
      wcnm_pkg::CLS_FLAT:  adv = adv_flat_r;
      wcnm_pkg::CLS_SAME:  adv = adv_same_r;
      default:             adv = '0;
    endcase
  end

  // Shift-and update; '0' keeps state zero, unknown bytes empty the set
  always_comb begin
    case (cmd.cls)
      wcnm_pkg::CLS_ZERO:  stepped = base_set & NUM_STATES'(1);
      wcnm_pkg::CLS_OTHER: stepped = '0;
      default:             stepped = {base_set[NUM_STATES-2:0] & adv, 1'b0}
                                     | (base_set & hold_r);
    endcase
  end

  // Accepting state test; lengths past the state count never hit
  assign set_wide = wcnm_pkg::MAX_STATES'(stepped);
  assign hit      = set_wide[len_r];

  // State and result next values
  always_comb begin
    set_nxt     = set_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    ovld_nxt    = ovld_r && !out_ready;
    now_nxt     = now_r;
    pos_nxt     = pos_r;
    done_nxt    = done_r;
    matched_nxt = matched_r;
    if (step) begin
      ovld_nxt    = 1'b1;
      now_nxt     = !base_found && hit;
      pos_nxt     = base_idx;
      done_nxt    = cmd.text_end;
      matched_nxt = base_found || hit;
      if (cmd.text_end) begin
        set_nxt   = NUM_STATES'(1);
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end else begin
        set_nxt   = stepped;
        idx_nxt   = (base_idx == '1) ? base_idx : base_idx + wcnm_pkg::POS_W'(1);
        found_nxt = base_found || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r   <= NUM_STATES'(1);
      idx_r   <= '0;
      found_r <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      set_r   <= set_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    pos_r     <= pos_nxt;
    done_r    <= done_nxt;
    matched_r <= matched_nxt;
  end

  assign out_valid          = ovld_r;
  assign out_match_now      = now_r;
  assign out_match_position = pos_r;
  assign out_text_done      = done_r;
  assign out_text_matched   = matched_r;

endmodule

[hw/rtl/wildcard_contour_nfa_matcher.sv]
// Wildcard melody-contour matcher, top level.
// Use:
//   in_*   : one text byte per transfer (in_symbol, in_text_start, in_text_end).
//   out_*  : one result per byte: first-match flag, byte position in its text,
//            end-of-text copy and the running matched flag.
//   cfg_*  : pattern register writes (index 0..6); cfg_ready is always high.
//            Write only while no bytes are in flight.
// Path: a byte passes the front register, then a queue slot, then the NFA
//   step into the result register.
// Throughput: one byte per cycle while out_ready stays high; the NFA step is
//   one masked shift and OR on the active set, combinational in the back end.
// When the receiver stalls the result register holds; the front stage and
//   the two-entry queue keep taking bytes until three are waiting, then
//   in_ready drops.
// Reset (rst_n low, synchronous): pattern registers return to their reset
//   values, the active set holds state zero only, and all stages empty.
// Depends on wcnm_pkg, wcnm_front, wcnm_queue and wcnm_back.
module wildcard_contour_nfa_matcher #(
  parameter int NUM_STATES = wcnm_pkg::NUM_STATES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [wcnm_pkg::SYM_W-1:0]       in_symbol,
  input  logic                             in_text_start,
  input  logic                             in_text_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_match_now,
  output logic [wcnm_pkg::POS_W-1:0]       out_match_position,
  output logic                             out_text_done,
  output logic                             out_text_matched,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wcnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           f_valid, f_ready;
  wcnm_pkg::cmd_t f_cmd;
  logic           q_valid, q_ready;
  wcnm_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  wcnm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_text_start (in_text_start),
    .in_text_end   (in_text_end),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  wcnm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  wcnm_back #(
    .NUM_STATES (NUM_STATES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd_valid          (q_valid),
    .cmd_ready          (q_ready),
    .cmd                (q_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_now      (out_match_now),
    .out_match_position (out_match_position),
    .out_text_done      (out_text_done),
    .out_text_matched   (out_text_matched)
  );

endmodule
